[rtl/hcm_pkg.sv]
// ----------------------------------------------------------------------------
// hcm_pkg: shared types and constants of the hotkey chord matcher
// Key index layout, default sizes and the item function codes.
// ----------------------------------------------------------------------------
package hcm_pkg;

    localparam int KB_SPAN      = 2048;     // keys per keyboard
    localparam int KEY_BITS     = 11;       // native flag plus 10-bit key
    localparam int CODE_W       = 16;       // rule entry width
    localparam int KST_W        = 3;        // per-key state width

    localparam int DEF_KEYBOARDS = 2;
    localparam int DEF_BUTTONS   = 64;
    localparam int DEF_CHAINS    = 4;
    localparam int DEF_MODIFIERS = 4;

    typedef enum logic [1:0] {
        FN_KEY   = 2'd0,
        FN_TICK  = 2'd1,
        FN_QUERY = 2'd2,
        FN_WRITE = 2'd3
    } t_func;

endpackage

[rtl/hcm_in_if.sv]
// ----------------------------------------------------------------------------
// hcm_in_if: input item channel
// Valid/ready channel carrying one key event, tick, query or rule write.
// ----------------------------------------------------------------------------
interface hcm_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  func;
    logic [4:0]  keyboard;
    logic [9:0]  scan_code;
    logic [9:0]  abstract_code;
    logic        key_down;
    logic [5:0]  button_id;
    logic        oneshot;
    logic [1:0]  chain_slot;
    logic [2:0]  entry_slot;
    logic [15:0] entry_code;

    modport source (
        output valid, func, keyboard, scan_code, abstract_code, key_down,
               button_id, oneshot, chain_slot, entry_slot, entry_code,
        input  ready
    );
    modport sink (
        input  valid, func, keyboard, scan_code, abstract_code, key_down,
               button_id, oneshot, chain_slot, entry_slot, entry_code,
        output ready
    );
endinterface

[rtl/hcm_out_if.sv]
// ----------------------------------------------------------------------------
// hcm_out_if: result channel
// Valid/ready channel carrying the one-bit answer of each item.
// ----------------------------------------------------------------------------
interface hcm_out_if;
    logic valid;
    logic ready;
    logic active;

    modport source (output valid, active, input ready);
    modport sink   (input valid, active, output ready);
endinterface

[rtl/hcm_ram.sv]
// ----------------------------------------------------------------------------
// hcm_ram: generic simple dual-port RAM
// One write port, one read port, read data registered.
// ----------------------------------------------------------------------------
module hcm_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

[rtl/hotkey_chord_matcher.sv]
// ----------------------------------------------------------------------------
// hotkey_chord_matcher: keyboard chord matcher for mapped buttons
// Per-key held/changed state and a chain rule table, both in block RAM.
// ----------------------------------------------------------------------------
// Usage: items arrive on i_in (valid/ready); every item gives exactly one
// result on o_out. Key events, frame ticks and rule writes answer 0; a
// button query answers 1 when one of its chains matches.
// Timing: one item is worked at a time, by a sequencer around two RAMs
// with registered reads. A frame tick ages one key state per cycle through
// the read-modify-write pipe. A query, per chain tried, loads the chain,
// looks up each of its keys, then walks the whole rule table entry by
// entry, with a key lookup for each relevant modifier.
// Reset: a clearing pass over max(KEYBOARDS*2048, BUTTONS*CHAINS*(MODIFIERS+1))
// addresses zeroes both RAMs; i_in.ready stays low meanwhile.
// Stall: the result sits in an output register; the next item is taken
// while it waits, and its own result is held back until o_out is free.
// ----------------------------------------------------------------------------
module hotkey_chord_matcher import hcm_pkg::*; #(
    parameter int KEYBOARDS = DEF_KEYBOARDS,
    parameter int BUTTONS   = DEF_BUTTONS,
    parameter int CHAINS    = DEF_CHAINS,
    parameter int MODIFIERS = DEF_MODIFIERS
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    hcm_in_if.sink    i_in,
    hcm_out_if.source o_out
);
    localparam int ENTRIES    = MODIFIERS + 1;
    localparam int KEY_DEPTH  = KEYBOARDS * KB_SPAN;
    localparam int KAW        = $clog2(KEY_DEPTH);
    localparam int RULE_DEPTH = BUTTONS * CHAINS * ENTRIES;
    localparam int RAW        = $clog2(RULE_DEPTH);
    localparam int CLR_DEPTH  = (KEY_DEPTH > RULE_DEPTH) ? KEY_DEPTH : RULE_DEPTH;
    localparam int CLW        = $clog2(CLR_DEPTH);
    localparam int CW         = (CHAINS > 1) ? $clog2(CHAINS) : 1;
    localparam int EW         = $clog2(ENTRIES);

    typedef enum logic [10:0] {
        S_CLEAR = 11'b000_0000_0001,
        S_IDLE  = 11'b000_0000_0010,
        S_KEY   = 11'b000_0000_0100,
        S_TICK  = 11'b000_0000_1000,
        S_LOAD  = 11'b000_0001_0000,
        S_BASE  = 11'b000_0010_0000,
        S_MODS  = 11'b000_0100_0000,
        S_SCAN  = 11'b000_1000_0000,
        S_SCHK  = 11'b001_0000_0000,
        S_DONE  = 11'b010_0000_0000,
        S_SPARE = 11'b100_0000_0000
    } t_state;

    t_state            r_state, n_state;
    logic [CLW-1:0]    r_clr, n_clr;
    logic [KAW-1:0]    r_kaddr, n_kaddr;
    logic              r_down, n_down;
    logic [KAW-1:0]    r_tcnt, n_tcnt;
    logic              r_tlive, n_tlive;
    logic              r_tv, n_tv;
    logic [KAW-1:0]    r_ta, n_ta;
    logic              r_wait, n_wait;
    logic              r_oneshot, n_oneshot;
    logic [CW-1:0]     r_c, n_c;
    logic [RAW-1:0]    r_cbase, n_cbase;
    logic [EW-1:0]     r_e, n_e;
    logic [CODE_W-1:0] r_chain [ENTRIES];
    logic [RAW-1:0]    r_scan, n_scan;
    logic [EW-1:0]     r_se, n_se;
    logic              r_omatch, n_omatch;
    logic [CODE_W-1:0] r_mod, n_mod;
    logic              r_res, n_res;
    logic              r_ov, n_ov;
    logic              r_oact, n_oact;

    logic              chain_we;
    logic [CODE_W-1:0] chain_wd;

    logic              k_we, k_re;
    logic [KAW-1:0]    k_waddr, k_raddr;
    logic [KST_W-1:0]  k_wdata, k_rdata;
    logic              r_we, r_re;
    logic [RAW-1:0]    r_waddr, r_raddr;
    logic [CODE_W-1:0] r_wdata, r_rdata;

    logic              acc;
    logic [KEY_BITS-1:0] ev_key;
    logic [CODE_W-1:0] base;
    logic [4:0]        base_kb;
    logic              in_chain;
    logic              scan_last;
    logic [KST_W-1:0]  tick_val;

    hcm_ram #(.WIDTH(KST_W), .DEPTH(KEY_DEPTH)) u_key_ram (
        .i_clk   (i_clk),
        .i_we    (k_we),
        .i_waddr (k_waddr),
        .i_wdata (k_wdata),
        .i_re    (k_re),
        .i_raddr (k_raddr),
        .o_rdata (k_rdata)
    );

    hcm_ram #(.WIDTH(CODE_W), .DEPTH(RULE_DEPTH)) u_rule_ram (
        .i_clk   (i_clk),
        .i_we    (r_we),
        .i_waddr (r_waddr),
        .i_wdata (r_wdata),
        .i_re    (r_re),
        .i_raddr (r_raddr),
        .o_rdata (r_rdata)
    );

    assign i_in.ready   = (r_state == S_IDLE);
    assign acc          = i_in.valid && i_in.ready;
    assign o_out.valid  = r_ov;
    assign o_out.active = r_oact;

    assign ev_key  = (i_in.abstract_code != 10'd0) ? {1'b0, i_in.abstract_code}
                                                   : {1'b1, i_in.scan_code};
    assign base    = r_chain[0];
    assign base_kb = base[15:11];
    assign scan_last = (r_scan == RAW'(RULE_DEPTH - 1));
    assign tick_val  = (k_rdata >= KST_W'(2)) ? (k_rdata - KST_W'(2)) : k_rdata;

    always_comb begin
        in_chain = 1'b0;
        for (int m = 1; m < ENTRIES; m++) begin
            if (r_chain[m] == r_rdata) begin
                in_chain = 1'b1;
            end
        end
    end

    // RAM port steering
    always_comb begin
        k_we    = 1'b0;
        k_waddr = r_kaddr;
        k_wdata = '0;
        k_re    = 1'b0;
        k_raddr = KAW'({base_kb, base[10:0]});
        r_we    = 1'b0;
        r_waddr = RAW'((int'(i_in.button_id) * CHAINS + int'(i_in.chain_slot)) * ENTRIES
                       + int'(i_in.entry_slot));
        r_wdata = i_in.entry_code;
        r_re    = 1'b0;
        r_raddr = r_cbase + RAW'(r_e);
        case (r_state)
            S_CLEAR: begin
                k_we    = (int'(r_clr) < KEY_DEPTH);
                k_waddr = r_clr[KAW-1:0];
                r_we    = (int'(r_clr) < RULE_DEPTH);
                r_waddr = r_clr[RAW-1:0];
                r_wdata = '0;
            end
            S_IDLE: begin
                k_re    = acc && (t_func'(i_in.func) == FN_KEY);
                k_raddr = KAW'({i_in.keyboard, ev_key});
                r_we    = acc && (t_func'(i_in.func) == FN_WRITE)
                          && (int'(i_in.button_id) < BUTTONS)
                          && (int'(i_in.chain_slot) < CHAINS)
                          && (int'(i_in.entry_slot) < ENTRIES);
            end
            S_KEY: begin
                k_we    = (k_rdata[0] != r_down);
                k_wdata = {1'b1, 1'b0, r_down};
            end
            S_TICK: begin
                k_re    = r_tlive;
                k_raddr = r_tcnt;
                k_we    = r_tv;
                k_waddr = r_ta;
                k_wdata = tick_val;
            end
            S_LOAD:  r_re = !r_wait;
            S_BASE:  k_re = !r_wait;
            S_MODS: begin
                k_re    = !r_wait;
                k_raddr = KAW'({base_kb, r_chain[r_e][10:0]});
            end
            S_SCAN: begin
                r_re    = !r_wait;
                r_raddr = r_scan;
            end
            S_SCHK: begin
                k_re    = !r_wait;
                k_raddr = KAW'({base_kb, r_mod[10:0]});
            end
            default: ;
        endcase
    end

    // sequencer
    always_comb begin
        n_state   = r_state;
        n_clr     = r_clr;
        n_kaddr   = r_kaddr;
        n_down    = r_down;
        n_tcnt    = r_tcnt;
        n_tlive   = r_tlive;
        n_tv      = 1'b0;
        n_ta      = r_tcnt;
        n_wait    = r_wait;
        n_oneshot = r_oneshot;
        n_c       = r_c;
        n_cbase   = r_cbase;
        n_e       = r_e;
        n_scan    = r_scan;
        n_se      = r_se;
        n_omatch  = r_omatch;
        n_mod     = r_mod;
        n_res     = r_res;
        n_ov      = r_ov && !o_out.ready;
        n_oact    = r_oact;
        chain_we  = 1'b0;
        chain_wd  = r_rdata;

        case (r_state)
            S_CLEAR: begin
                n_clr = r_clr + CLW'(1);
                if (r_clr == CLW'(CLR_DEPTH - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (acc) begin
                    n_res   = 1'b0;
                    n_state = S_DONE;
                    n_wait  = 1'b0;
                    case (t_func'(i_in.func))
                        FN_KEY: begin
                            if (int'(i_in.keyboard) < KEYBOARDS) begin
                                n_kaddr = KAW'({i_in.keyboard, ev_key});
                                n_down  = i_in.key_down;
                                n_state = S_KEY;
                            end
                        end
                        FN_TICK: begin
                            n_tcnt  = '0;
                            n_tlive = 1'b1;
                            n_state = S_TICK;
                        end
                        FN_QUERY: begin
                            if (int'(i_in.button_id) < BUTTONS) begin
                                n_oneshot = i_in.oneshot;
                                n_c       = '0;
                                n_cbase   = RAW'(int'(i_in.button_id) * CHAINS * ENTRIES);
                                n_e       = '0;
                                n_state   = S_LOAD;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            S_KEY: n_state = S_DONE;
            S_TICK: begin
                // issue one read a cycle, write back the aged value behind it
                n_tv = r_tlive;
                if (r_tlive) begin
                    n_tcnt = r_tcnt + KAW'(1);
                    if (r_tcnt == KAW'(KEY_DEPTH - 1)) begin
                        n_tlive = 1'b0;
                    end
                end
                if (r_tv && r_ta == KAW'(KEY_DEPTH - 1)) begin
                    n_state = S_DONE;
                end
            end
            S_LOAD: begin
                n_wait = !r_wait;
                if (r_wait) begin
                    chain_we = 1'b1;
                    if (r_e == EW'(MODIFIERS)) begin
                        n_e     = '0;
                        n_state = S_BASE;
                    end else begin
                        n_e = r_e + EW'(1);
                    end
                end
            end
            S_BASE: begin
                if (base == '0 || int'(base_kb) >= KEYBOARDS) begin
                    n_state = S_SPARE;
                end else begin
                    n_wait = !r_wait;
                    if (r_wait) begin
                        if (!k_rdata[0] || (r_oneshot && k_rdata != KST_W'(3))) begin
                            n_state = S_SPARE;
                        end else begin
                            n_e     = EW'(1);
                            n_state = S_MODS;
                        end
                    end
                end
            end
            S_MODS: begin
                if (!r_wait && r_chain[r_e] != '0) begin
                    n_wait = 1'b1;
                end else if (r_wait && !k_rdata[0]) begin
                    n_wait  = 1'b0;
                    n_state = S_SPARE;
                end else begin
                    n_wait = 1'b0;
                    if (r_e == EW'(MODIFIERS)) begin
                        n_scan   = '0;
                        n_se     = '0;
                        n_omatch = 1'b0;
                        n_state  = S_SCAN;
                    end else begin
                        n_e = r_e + EW'(1);
                    end
                end
            end
            S_SCAN, S_SCHK: begin
                n_wait = !r_wait;
                if (r_wait) begin
                    if (r_state == S_SCHK && k_rdata[0]) begin
                        // a held modifier of a same-base rule is missing here
                        n_state = S_SPARE;
                    end else if (r_state == S_SCAN && r_se != '0 && r_omatch
                                 && r_rdata != '0 && !in_chain) begin
                        n_mod   = r_rdata;
                        n_state = S_SCHK;
                    end else begin
                        if (r_state == S_SCAN && r_se == '0) begin
                            n_omatch = (r_rdata == base);
                        end
                        n_state = S_SCAN;
                        if (scan_last) begin
                            n_res   = 1'b1;
                            n_state = S_DONE;
                        end else begin
                            n_scan = r_scan + RAW'(1);
                            n_se   = (r_se == EW'(MODIFIERS)) ? '0 : r_se + EW'(1);
                        end
                    end
                end
            end
            S_SPARE: begin
                // chain failed: try the next one or answer 0
                n_wait = 1'b0;
                if (r_c == CW'(CHAINS - 1)) begin
                    n_res   = 1'b0;
                    n_state = S_DONE;
                end else begin
                    n_c     = r_c + CW'(1);
                    n_cbase = r_cbase + RAW'(ENTRIES);
                    n_e     = '0;
                    n_state = S_LOAD;
                end
            end
            S_DONE: begin
                if (!r_ov || o_out.ready) begin
                    n_ov    = 1'b1;
                    n_oact  = r_res;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_clr   <= '0;
            r_tlive <= 1'b0;
            r_tv    <= 1'b0;
            r_wait  <= 1'b0;
            r_ov    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_clr   <= n_clr;
            r_tlive <= n_tlive;
            r_tv    <= n_tv;
            r_wait  <= n_wait;
            r_ov    <= n_ov;
        end
    end

    always_ff @(posedge i_clk) begin
        r_kaddr   <= n_kaddr;
        r_down    <= n_down;
        r_tcnt    <= n_tcnt;
        r_ta      <= n_ta;
        r_oneshot <= n_oneshot;
        r_c       <= n_c;
        r_cbase   <= n_cbase;
        r_e       <= n_e;
        r_scan    <= n_scan;
        r_se      <= n_se;
        r_omatch  <= n_omatch;
        r_mod     <= n_mod;
        r_res     <= n_res;
        r_oact    <= n_oact;
        if (chain_we) begin
            r_chain[r_e] <= chain_wd;
        end
    end
endmodule

[tb/hotkey_chord_matcher_test.sv]
// ----------------------------------------------------------------------------
// hotkey_chord_matcher_test: self-checking bench for the hotkey chord matcher
// Runs a short directed table and then random key events, ticks, queries and
// rule writes. A behavioural copy of the key and rule state predicts every
// answer the table leaves open; random idling is applied on both channels.
// ----------------------------------------------------------------------------
module hotkey_chord_matcher_test;
    import hcm_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int NKB   = DEF_KEYBOARDS;
    localparam int NBTN  = DEF_BUTTONS;
    localparam int NCH   = DEF_CHAINS;
    localparam int NMOD  = DEF_MODIFIERS;
    localparam int NENT  = NMOD + 1;
    localparam int NKEYS = NKB * KB_SPAN;
    localparam int NRULE = NBTN * NCH * NENT;
    localparam int N_RANDOM = 930;
    localparam int N_CALM   = 150;

    typedef struct {
        t_func       fn;
        bit [4:0]    kb;
        bit [9:0]    scan;
        bit [9:0]    abs_code;
        bit          down;
        bit [5:0]    btn;
        bit          osh;
        bit [1:0]    cs;
        bit [2:0]    es;
        bit [15:0]   code;
        bit          known;
        bit          answer;
    } t_hk_item;

    logic clk;
    logic rst_n;

    hcm_in_if  in_ch();
    hcm_out_if out_ch();

    hotkey_chord_matcher DUT (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    bit [KST_W-1:0]  key_st [NKEYS];
    bit [CODE_W-1:0] rules  [NRULE];
    bit              answer_q [$];
    bit [15:0]       key_pool [8];
    bit              idle_on = 1;
    int              stall_left = 0;
    int              fails = 0;
    int              n_items = 0;
    int              n_queries = 0;
    int              n_hits = 0;

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial begin
        #400_000_000;
        $display("hotkey_chord_matcher_test: FAIL");
        $finish;
    end

    function automatic bit held(int kb, bit [15:0] code);
        return key_st[kb * KB_SPAN + int'(code[10:0])][0];
    endfunction

    function automatic bit chain_hit(int b, int c, bit osh);
        int base_at;
        int kb;
        bit [15:0] base;
        bit [2:0] st;
        bit found;
        base_at = (b * NCH + c) * NENT;
        base = rules[base_at];
        if (base == 0) return 0;
        kb = int'(base[15:11]);
        if (kb >= NKB) return 0;
        st = key_st[kb * KB_SPAN + int'(base[10:0])];
        if (!st[0]) return 0;
        if (osh && st != 3'd3) return 0;
        for (int m = 1; m < NENT; m++)
            if (rules[base_at + m] != 0 && !held(kb, rules[base_at + m])) return 0;
        // every held modifier of a rule on the same base must be in this chain
        for (int o = 0; o < NBTN * NCH; o++) begin
            if (rules[o * NENT] != base) continue;
            for (int m = 1; m < NENT; m++) begin
                if (rules[o * NENT + m] == 0 || !held(kb, rules[o * NENT + m])) continue;
                found = 0;
                for (int k = 1; k < NENT; k++)
                    if (rules[base_at + k] == rules[o * NENT + m]) found = 1;
                if (!found) return 0;
            end
        end
        return 1;
    endfunction

    // advance the shadow state by one item and return its answer
    function automatic bit chord_answer(t_hk_item it);
        int idx;
        bit hit;
        hit = 0;
        case (it.fn)
            FN_KEY: begin
                if (int'(it.kb) < NKB) begin
                    idx = int'(it.kb) * KB_SPAN +
                          int'((it.abs_code != 0) ? {1'b0, it.abs_code}
                                                  : {1'b1, it.scan});
                    if (key_st[idx][0] != it.down) key_st[idx] = 3'(4 + int'(it.down));
                end
            end
            FN_TICK: begin
                for (int i = 0; i < NKEYS; i++)
                    if (key_st[i] >= 2) key_st[i] = key_st[i] - 3'd2;
            end
            FN_QUERY: begin
                if (int'(it.btn) < NBTN)
                    for (int c = 0; c < NCH && !hit; c++)
                        hit = chain_hit(int'(it.btn), c, it.osh);
            end
            FN_WRITE: begin
                if (int'(it.btn) < NBTN && int'(it.cs) < NCH && int'(it.es) < NENT)
                    rules[(int'(it.btn) * NCH + int'(it.cs)) * NENT + int'(it.es)] = it.code;
            end
            default: ;
        endcase
        return hit;
    endfunction

    function automatic t_hk_item mk(t_func fn, int kb, int scan, int abs_code, bit down,
                                    int btn, bit osh, int cs, int es, int code,
                                    bit known, bit answer);
        t_hk_item it;
        it.fn = fn; it.kb = 5'(kb); it.scan = 10'(scan); it.abs_code = 10'(abs_code);
        it.down = down; it.btn = 6'(btn); it.osh = osh; it.cs = 2'(cs); it.es = 3'(es);
        it.code = 16'(code); it.known = known; it.answer = answer;
        return it;
    endfunction

    task automatic send(t_hk_item it);
        bit a;
        if (idle_on && $urandom_range(0, 3) == 0) begin
            in_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 13)) @(posedge clk);
        end
        in_ch.valid         <= 1'b1;
        in_ch.func          <= it.fn;
        in_ch.keyboard      <= it.kb;
        in_ch.scan_code     <= it.scan;
        in_ch.abstract_code <= it.abs_code;
        in_ch.key_down      <= it.down;
        in_ch.button_id     <= it.btn;
        in_ch.oneshot       <= it.osh;
        in_ch.chain_slot    <= it.cs;
        in_ch.entry_slot    <= it.es;
        in_ch.entry_code    <= it.code;
        do @(posedge clk); while (!in_ch.ready);
        a = chord_answer(it);
        answer_q.push_back(it.known ? it.answer : a);
        n_items++;
        if (it.fn == FN_QUERY) begin
            n_queries++;
            n_hits += int'(a);
        end
    endtask

    function automatic t_hk_item rand_item();
        t_hk_item it;
        bit [15:0] k;
        int sel;
        it = mk(FN_KEY, $urandom, $urandom, $urandom, 1'($urandom), $urandom,
                1'($urandom), $urandom, $urandom, $urandom, 0, 0);
        it.fn = t_func'(2'($urandom_range(0, 3)));
        sel = $urandom_range(0, 99);
        k = key_pool[$urandom_range(0, 7)];
        if (sel < 38) begin
            // press or release a key that the rules know about
            it.fn = FN_KEY;
            it.kb = k[15:11];
            if (k[10]) begin
                it.abs_code = 10'd0;
                it.scan = k[9:0];
            end else begin
                it.abs_code = k[9:0];
            end
        end else if (sel < 46) begin
            it.fn = FN_TICK;
        end else if (sel < 64) begin
            it.fn = FN_QUERY;
            it.btn = 6'($urandom_range(0, 7));
        end else if (sel < 90) begin
            it.fn = FN_WRITE;
            it.btn = 6'($urandom_range(0, 7));
            it.es = 3'($urandom_range(0, NMOD));
            it.code = ($urandom_range(0, 9) == 0) ? 16'h0 : k;
        end
        return it;
    endfunction

    always @(posedge clk) begin
        logic nxt;
        if (rst_n && out_ch.valid && out_ch.ready) begin
            if (answer_q.size() == 0) begin
                fails++;
                if (fails <= 10) $display("unexpected result %0b", out_ch.active);
            end else begin
                if (out_ch.active !== answer_q[0]) begin
                    fails++;
                    if (fails <= 10)
                        $display("mismatch: expected active=%0b got %0b",
                                 answer_q[0], out_ch.active);
                end
                void'(answer_q.pop_front());
            end
        end
        // hold ready low for a burst, else keep it high
        nxt = 1'b1;
        if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            nxt = 1'b0;
        end else if (idle_on && $urandom_range(0, 5) == 0) begin
            stall_left <= $urandom_range(0, 12);
            nxt = 1'b0;
        end
        out_ch.ready <= nxt;
    end

    initial begin
        t_hk_item rows [24];
        int wait_cnt;
        rst_n <= 1'b0;
        in_ch.valid <= 1'b0;
        in_ch.func <= FN_KEY;
        in_ch.keyboard <= '0; in_ch.scan_code <= '0; in_ch.abstract_code <= '0;
        in_ch.key_down <= 1'b0; in_ch.button_id <= '0; in_ch.oneshot <= 1'b0;
        in_ch.chain_slot <= '0; in_ch.entry_slot <= '0; in_ch.entry_code <= '0;
        for (int i = 0; i < 8; i++) begin
            key_pool[i][15:11] = (i == 7) ? 5'd2 : ((i < 4) ? 5'd0 : 5'd1);
            key_pool[i][10]    = i[0];
            key_pool[i][9:0]   = 10'($urandom_range(1, 1023));
        end

        rows[0]  = mk(FN_TICK,  0, 0, 0, 0, 0, 0, 0, 0, 0, 1, 0);
        rows[1]  = mk(FN_QUERY, 0, 0, 0, 0, 63, 0, 0, 0, 0, 1, 0);
        rows[2]  = mk(FN_QUERY, 0, 0, 0, 0, 0, 0, 0, 0, 0, 1, 0);
        rows[3]  = mk(FN_WRITE, 0, 0, 0, 0, 0, 0, 0, 0, 16'h0005, 1, 0);
        rows[4]  = mk(FN_WRITE, 0, 0, 0, 0, 0, 0, 0, 1, 16'h0407, 1, 0);
        rows[5]  = mk(FN_WRITE, 0, 0, 0, 0, 0, 0, 3, 4, 16'hFFFF, 1, 0);
        rows[6]  = mk(FN_WRITE, 0, 0, 0, 0, 63, 0, 3, 0, 16'hFFFF, 1, 0);
        rows[7]  = mk(FN_WRITE, 0, 0, 0, 0, 1, 0, 1, 7, 16'h1234, 1, 0);
        rows[8]  = mk(FN_KEY,   0, 0, 5, 1, 0, 0, 0, 0, 0, 1, 0);
        rows[9]  = mk(FN_QUERY, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0);
        rows[10] = mk(FN_KEY,   0, 7, 0, 1, 0, 0, 0, 0, 0, 1, 0);
        rows[11] = mk(FN_QUERY, 0, 0, 0, 0, 0, 1, 0, 0, 0, 0, 0);
        rows[12] = mk(FN_TICK,  0, 0, 0, 0, 0, 0, 0, 0, 0, 1, 0);
        rows[13] = mk(FN_QUERY, 0, 0, 0, 0, 0, 1, 0, 0, 0, 0, 0);
        rows[14] = mk(FN_KEY,   31, 1023, 1023, 1, 0, 0, 0, 0, 0, 1, 0);
        rows[15] = mk(FN_KEY,   1, 0, 1023, 1, 0, 0, 0, 0, 0, 1, 0);
        rows[16] = mk(FN_WRITE, 0, 0, 0, 0, 2, 0, 0, 0, 16'h0005, 1, 0);
        rows[17] = mk(FN_WRITE, 0, 0, 0, 0, 2, 0, 0, 1, 16'h0009, 1, 0);
        rows[18] = mk(FN_KEY,   0, 0, 9, 1, 0, 0, 0, 0, 0, 1, 0);
        rows[19] = mk(FN_QUERY, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0);
        rows[20] = mk(FN_QUERY, 0, 0, 0, 0, 63, 1, 0, 0, 0, 0, 0);
        rows[21] = mk(FN_KEY,   0, 0, 5, 0, 0, 0, 0, 0, 0, 1, 0);
        rows[22] = mk(FN_TICK,  0, 0, 0, 0, 0, 0, 0, 0, 0, 1, 0);
        rows[23] = mk(FN_QUERY, 0, 0, 0, 0, 2, 0, 0, 0, 0, 0, 0);

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        foreach (rows[i]) send(rows[i]);
        for (int i = 0; i < N_RANDOM; i++) begin
            if (i == N_RANDOM - N_CALM) idle_on = 0;
            send(rand_item());
        end
        in_ch.valid <= 1'b0;

        wait_cnt = 0;
        while (answer_q.size() != 0 && wait_cnt < 20_000_000) begin
            @(posedge clk);
            wait_cnt++;
        end
        repeat (50) @(posedge clk);

        $display("%0d items sent, %0d queries of which %0d active; %0d mismatches",
                 n_items, n_queries, n_hits, fails);
        if (fails == 0 && answer_q.size() == 0) begin
            $display("hotkey_chord_matcher_test: PASS");
        end else begin
            $display("hotkey_chord_matcher_test: FAIL");
        end
        $finish;
    end
endmodule
